@@ rtl/sbqt_pkg.sv @@
`timescale 1ns / 1ps
package sbqt_pkg;

  // Operation codes
  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_RM_HEAD  = 3'd1;
  localparam logic [2:0] OP_RM_PCB   = 3'd2;
  localparam logic [2:0] OP_PEEK     = 3'd3;
  localparam logic [2:0] OP_BUSY     = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_NULL     = 3'd3,
    ST_BLOCKED  = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] sem_key;
    logic [4:0]  pcb_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic       pcb_valid;
    logic [4:0] pcb_out;
    logic       queue_empty;
  } out_word_t;

endpackage

@@ rtl/sbqt_if.sv @@
`timescale 1ns / 1ps
interface sbqt_in_if import sbqt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbqt_out_if import sbqt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/semaphore_blocked_queue_table_unit.sv @@
`timescale 1ns / 1ps
// A key search reads the descriptors one at a time, comparing each key after its
// read; removing a given process reads its descriptor, then walks its queue one
// link at a time (at most NUM_PROCS links). Invalid or null words go straight to the result.
// One word is in flight at a time; the next is taken once the result is taken.
// Reset (synchronous, active low) clears the control state and the descriptor
// used and process blocked bits; the memories themselves are not cleared.
module semaphore_blocked_queue_table_unit
  import sbqt_pkg::*;
#(
  parameter int NUM_PROCS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  sbqt_in_if.sink      in_ch,
  sbqt_out_if.source   out_ch
);

  localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_PROCS - 1);

  typedef logic [IW-1:0] idx_t;

  typedef struct packed {
    logic [31:0] key;
    idx_t        head;
    idx_t        tail;
  } desc_t;

  typedef struct packed {
    logic has_next;
    idx_t next;
  } link_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRD   = 9'b000000010,
    S_SCMP  = 9'b000000100,
    S_INS   = 9'b000001000,
    S_UHEAD = 9'b000010000,
    S_PDESC = 9'b000100000,
    S_PDRD  = 9'b001000000,
    S_WALK  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  function automatic idx_t to_idx(input logic [4:0] v);
    logic [IW+4:0] w;
    w = {{IW{1'b0}}, v};
    return w[IW-1:0];
  endfunction

  function automatic logic [4:0] from_idx(input idx_t v);
    logic [IW+4:0] w;
    w = {5'd0, v};
    return w[4:0];
  endfunction

  // Memories
  desc_t desc_mem [NUM_PROCS];
  link_t link_mem [NUM_PROCS];
  idx_t  pdesc_mem [NUM_PROCS];

  logic  desc_we, desc_re, link_we, link_re, pdesc_we, pdesc_re;
  idx_t  desc_wa, desc_ra, link_wa, link_ra, pdesc_wa, pdesc_ra;
  desc_t desc_wd, desc_rd;
  link_t link_wd, link_rd;
  idx_t  pdesc_wd, pdesc_rd;

  always_ff @(posedge clk) begin
    if (desc_we) desc_mem[desc_wa] <= desc_wd;
    if (desc_re) desc_rd <= desc_mem[desc_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rd <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (pdesc_we) pdesc_mem[pdesc_wa] <= pdesc_wd;
    if (pdesc_re) pdesc_rd <= pdesc_mem[pdesc_ra];
  end

  // Control and working registers
  state_t                 state_r, state_nxt;
  logic [NUM_PROCS-1:0]   used_r, used_nxt;
  logic [NUM_PROCS-1:0]   blocked_r, blocked_nxt;
  logic [2:0]             op_r, op_nxt;
  logic [31:0]            key_r, key_nxt;
  idx_t                   pid_r, pid_nxt;
  idx_t                   cnt_r, cnt_nxt;
  logic                   free_ok_r, free_ok_nxt;
  idx_t                   free_r, free_nxt;
  idx_t                   d_r, d_nxt;
  desc_t                  dsc_r, dsc_nxt;
  link_t                  plink_r, plink_nxt;
  idx_t                   prev_r, prev_nxt;
  status_t                st_r, st_nxt;
  logic                   pv_r, pv_nxt;
  idx_t                   pout_r, pout_nxt;
  logic                   qe_r, qe_nxt;

  logic pid_ok;
  idx_t in_pidx;

  assign in_pidx = to_idx(in_ch.data.pcb_id);
  assign pid_ok  = ({27'd0, in_ch.data.pcb_id} < 32'(NUM_PROCS));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_RESP);
  assign out_ch.data.status      = st_r;
  assign out_ch.data.pcb_valid   = pv_r;
  assign out_ch.data.pcb_out     = from_idx(pout_r);
  assign out_ch.data.queue_empty = qe_r;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    blocked_nxt = blocked_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    pid_nxt     = pid_r;
    cnt_nxt     = cnt_r;
    free_ok_nxt = free_ok_r;
    free_nxt    = free_r;
    d_nxt       = d_r;
    dsc_nxt     = dsc_r;
    plink_nxt   = plink_r;
    prev_nxt    = prev_r;
    st_nxt      = st_r;
    pv_nxt      = pv_r;
    pout_nxt    = pout_r;
    qe_nxt      = qe_r;
    desc_we = 1'b0; desc_wa = d_r; desc_wd = dsc_r;
    desc_re = 1'b0; desc_ra = cnt_r;
    link_we = 1'b0; link_wa = pid_r; link_wd = '0;
    link_re = 1'b0; link_ra = pid_r;
    pdesc_we = 1'b0; pdesc_wa = pid_r; pdesc_wd = d_r;
    pdesc_re = 1'b0; pdesc_ra = pid_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt      = in_ch.data.op;
          key_nxt     = in_ch.data.sem_key;
          pid_nxt     = in_pidx;
          cnt_nxt     = '0;
          free_ok_nxt = 1'b0;
          st_nxt      = ST_NULL;
          pv_nxt      = 1'b0;
          pout_nxt    = '0;
          qe_nxt      = 1'b0;
          state_nxt   = S_RESP;
          case (in_ch.data.op)
            OP_INSERT: begin
              if (in_ch.data.sem_key != 32'd0 && pid_ok) begin
                if (blocked_r[in_pidx]) st_nxt = ST_BLOCKED;
                else state_nxt = S_SRD;
              end
            end
            OP_RM_HEAD, OP_PEEK: begin
              if (in_ch.data.sem_key != 32'd0) state_nxt = S_SRD;
            end
            OP_RM_PCB: begin
              if (pid_ok) begin
                if (!blocked_r[in_pidx]) begin
                  st_nxt = ST_NOTFOUND;
                end else begin
                  pdesc_re  = 1'b1;
                  pdesc_ra  = in_pidx;
                  link_re   = 1'b1;
                  link_ra   = in_pidx;
                  state_nxt = S_PDESC;
                end
              end
            end
            OP_BUSY: begin
              st_nxt = ST_OK;
              qe_nxt = 1'b1;
              if (in_ch.data.sem_key != 32'd0) state_nxt = S_SRD;
            end
            default: st_nxt = ST_NULL;
          endcase
        end
      end

      // Read one descriptor of the key search
      S_SRD: begin
        desc_re   = 1'b1;
        desc_ra   = cnt_r;
        state_nxt = S_SCMP;
      end

      S_SCMP: begin
        if (used_r[cnt_r] && desc_rd.key == key_r) begin
          d_nxt   = cnt_r;
          dsc_nxt = desc_rd;
          case (op_r)
            OP_BUSY: begin
              qe_nxt = 1'b0; st_nxt = ST_OK; state_nxt = S_RESP;
            end
            OP_PEEK: begin
              st_nxt = ST_OK; pv_nxt = 1'b1; pout_nxt = desc_rd.head;
              state_nxt = S_RESP;
            end
            OP_RM_HEAD: begin
              pid_nxt   = desc_rd.head;
              link_re   = 1'b1;
              link_ra   = desc_rd.head;
              state_nxt = S_UHEAD;
            end
            default: begin
              // append behind the current tail
              link_we   = 1'b1;
              link_wa   = desc_rd.tail;
              link_wd   = '{has_next: 1'b1, next: pid_r};
              desc_we   = 1'b1;
              desc_wa   = cnt_r;
              desc_wd   = '{key: desc_rd.key, head: desc_rd.head, tail: pid_r};
              state_nxt = S_INS;
            end
          endcase
        end else begin
          if (!used_r[cnt_r] && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_nxt    = cnt_r;
          end
          if (cnt_r != LAST) begin
            cnt_nxt   = cnt_r + idx_t'(1);
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_RESP;
            case (op_r)
              OP_BUSY: begin
                qe_nxt = 1'b1; st_nxt = ST_OK;
              end
              OP_INSERT: begin
                if (free_ok_r || !used_r[cnt_r]) begin
                  d_nxt   = free_ok_r ? free_r : cnt_r;
                  desc_we = 1'b1;
                  desc_wa = free_ok_r ? free_r : cnt_r;
                  desc_wd = '{key: key_r, head: pid_r, tail: pid_r};
                  used_nxt[free_ok_r ? free_r : cnt_r] = 1'b1;
                  state_nxt = S_INS;
                end else begin
                  st_nxt = ST_FULL;
                end
              end
              default: st_nxt = ST_NOTFOUND;
            endcase
          end
        end
      end

      // Close the new tail entry
      S_INS: begin
        link_we  = 1'b1;
        link_wa  = pid_r;
        link_wd  = '{has_next: 1'b0, next: '0};
        pdesc_we = 1'b1;
        pdesc_wa = pid_r;
        pdesc_wd = d_r;
        blocked_nxt[pid_r] = 1'b1;
        st_nxt    = ST_OK;
        state_nxt = S_RESP;
      end

      // Pop the head process (link data of the head is in link_rd)
      S_UHEAD: begin
        if (link_rd.has_next) begin
          desc_we = 1'b1;
          desc_wa = d_r;
          desc_wd = '{key: dsc_r.key, head: link_rd.next, tail: dsc_r.tail};
        end else begin
          used_nxt[d_r] = 1'b0;
        end
        blocked_nxt[pid_r] = 1'b0;
        st_nxt    = ST_OK;
        pv_nxt    = 1'b1;
        pout_nxt  = pid_r;
        state_nxt = S_RESP;
      end

      S_PDESC: begin
        d_nxt     = pdesc_rd;
        plink_nxt = link_rd;
        desc_re   = 1'b1;
        desc_ra   = pdesc_rd;
        state_nxt = S_PDRD;
      end

      S_PDRD: begin
        dsc_nxt = desc_rd;
        if (!used_r[d_r]) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_RESP;
        end else if (desc_rd.head == pid_r) begin
          // link_rd still holds this process's link
          state_nxt = S_UHEAD;
        end else begin
          prev_nxt  = desc_rd.head;
          cnt_nxt   = '0;
          link_re   = 1'b1;
          link_ra   = desc_rd.head;
          state_nxt = S_WALK;
        end
      end

      // Walk the queue one link a cycle
      S_WALK: begin
        if (!link_rd.has_next) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_RESP;
        end else if (link_rd.next == pid_r) begin
          link_we = 1'b1;
          link_wa = prev_r;
          link_wd = plink_r;
          if (dsc_r.tail == pid_r) begin
            desc_we = 1'b1;
            desc_wa = d_r;
            desc_wd = '{key: dsc_r.key, head: dsc_r.head, tail: prev_r};
          end
          blocked_nxt[pid_r] = 1'b0;
          st_nxt    = ST_OK;
          pv_nxt    = 1'b1;
          pout_nxt  = pid_r;
          state_nxt = S_RESP;
        end else if (cnt_r == LAST) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_RESP;
        end else begin
          prev_nxt = link_rd.next;
          cnt_nxt  = cnt_r + idx_t'(1);
          link_re  = 1'b1;
          link_ra  = link_rd.next;
        end
      end

      // Hold the result until taken
      S_RESP: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      blocked_r <= '0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      blocked_r <= blocked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    pid_r     <= pid_nxt;
    cnt_r     <= cnt_nxt;
    free_ok_r <= free_ok_nxt;
    free_r    <= free_nxt;
    d_r       <= d_nxt;
    dsc_r     <= dsc_nxt;
    plink_r   <= plink_nxt;
    prev_r    <= prev_nxt;
    st_r      <= st_nxt;
    pv_r      <= pv_nxt;
    pout_r    <= pout_nxt;
    qe_r      <= qe_nxt;
  end

  // A word is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while result pending");

  // A process is only returned with an ok status
  a_pcb_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.pcb_valid) |-> (out_ch.data.status == ST_OK))
    else $error("process returned with failing status");

  // A taken insert of a blocked process leaves the blocked bits alone
  a_blocked_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.status == ST_BLOCKED) |-> $stable(blocked_r))
    else $error("blocked bits changed on rejected insert");

endmodule

@@ tb/sbqt_tb_if.sv @@
`timescale 1ns / 1ps
// The channel interfaces sbqt_in_if and sbqt_out_if come with the RTL
// (rtl/sbqt_if.sv). The checker keeps its own helper types here.
package sbqt_tb_pkg;
  import sbqt_pkg::*;

  // Share of cycles, in percent, on which each side of the link idles
  typedef struct {
    int unsigned src_idle;
    int unsigned snk_stall;
  } idle_mix_t;
endpackage

@@ tb/semaphore_blocked_queue_table_unit_tb.sv @@
`timescale 1ns / 1ps
module semaphore_blocked_queue_table_unit_tb;
  import sbqt_pkg::*;
  import sbqt_tb_pkg::*;

  localparam int NPROC = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sbqt_in_if  in_ch ();
  sbqt_out_if out_ch ();

  semaphore_blocked_queue_table_unit #(.NUM_PROCS(NPROC)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // Copy of the semaphore table, kept in step with the words sent
  logic        sem_used [NPROC];
  logic [31:0] sem_key  [NPROC];
  logic [4:0]  sem_head [NPROC];
  logic [4:0]  sem_tail [NPROC];
  logic [4:0]  pid_next [NPROC];
  logic        pid_more [NPROC];
  logic        pid_blk  [NPROC];
  logic [4:0]  pid_sem  [NPROC];

  in_word_t  pending_words [$];
  out_word_t expected_results [$];
  idle_mix_t idle_mix;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  logic [31:0] keys [8];

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic int find_sem(input logic [31:0] k);
    if (k == 32'd0) return -1;
    for (int d = 0; d < NPROC; d++)
      if (sem_used[d] && sem_key[d] == k) return d;
    return -1;
  endfunction

  // Take process p out of the queue of descriptor d; free d once empty
  function automatic bit unlink_pid(input int d, input int p);
    int prev;
    int n;
    if (d >= NPROC || p >= NPROC || !sem_used[d]) return 0;
    if (sem_head[d] == p) begin
      if (pid_more[p]) sem_head[d] = pid_next[p];
      else sem_used[d] = 1'b0;
      pid_blk[p] = 1'b0;
      return 1;
    end
    prev = sem_head[d];
    for (int i = 0; i < NPROC; i++) begin
      if (prev >= NPROC || !pid_more[prev]) return 0;
      n = pid_next[prev];
      if (n == p) begin
        pid_more[prev] = pid_more[p];
        pid_next[prev] = pid_next[p];
        if (sem_tail[d] == p) sem_tail[d] = prev[4:0];
        pid_blk[p] = 1'b0;
        return 1;
      end
      prev = n;
    end
    return 0;
  endfunction

  function automatic out_word_t apply_sem_op(input in_word_t w);
    out_word_t r;
    int d;
    int pid;
    pid = w.pcb_id;
    r = '0;
    r.status = ST_NULL;
    case (w.op)
      OP_INSERT: begin
        if (w.sem_key == 0 || pid >= NPROC) r.status = ST_NULL;
        else if (pid_blk[pid]) r.status = ST_BLOCKED;
        else begin
          d = find_sem(w.sem_key);
          if (d >= 0) begin
            pid_more[sem_tail[d]] = 1'b1;
            pid_next[sem_tail[d]] = pid[4:0];
            sem_tail[d] = pid[4:0];
          end else begin
            for (d = 0; d < NPROC; d++)
              if (!sem_used[d]) break;
            if (d >= NPROC) begin
              r.status = ST_FULL;
              return r;
            end
            sem_used[d] = 1'b1;
            sem_key[d] = w.sem_key;
            sem_head[d] = pid[4:0];
            sem_tail[d] = pid[4:0];
          end
          pid_more[pid] = 1'b0;
          pid_next[pid] = '0;
          pid_blk[pid] = 1'b1;
          pid_sem[pid] = d[4:0];
          r.status = ST_OK;
        end
      end
      OP_RM_HEAD, OP_PEEK: begin
        if (w.sem_key == 0) r.status = ST_NULL;
        else begin
          d = find_sem(w.sem_key);
          if (d < 0) r.status = ST_NOTFOUND;
          else begin
            r.pcb_out = sem_head[d];
            r.pcb_valid = 1'b1;
            r.status = ST_OK;
            if (w.op == OP_RM_HEAD) void'(unlink_pid(d, sem_head[d]));
          end
        end
      end
      OP_RM_PCB: begin
        if (pid >= NPROC) r.status = ST_NULL;
        else if (!pid_blk[pid] || !unlink_pid(pid_sem[pid], pid)) r.status = ST_NOTFOUND;
        else begin
          r.status = ST_OK;
          r.pcb_valid = 1'b1;
          r.pcb_out = pid[4:0];
        end
      end
      OP_BUSY: begin
        r.status = ST_OK;
        r.queue_empty = (find_sem(w.sem_key) < 0);
      end
      default: r.status = ST_NULL;
    endcase
    return r;
  endfunction

  function automatic in_word_t mk(input logic [2:0] op, input logic [31:0] k,
                                  input logic [4:0] p);
    in_word_t w;
    w.op = op;
    w.sem_key = k;
    w.pcb_id = p;
    return w;
  endfunction

  // Random word: mostly keys from the key set and in-range processes
  function automatic in_word_t rand_word();
    logic [2:0] op;
    logic [31:0] k;
    logic [4:0] p;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_INSERT;
    else if (r < 58) op = OP_RM_HEAD;
    else if (r < 76) op = OP_RM_PCB;
    else if (r < 86) op = OP_PEEK;
    else if (r < 96) op = OP_BUSY;
    else op = 3'($urandom_range(5, 7));
    r = $urandom_range(0, 99);
    if (r < 85) k = keys[$urandom_range(0, 7)];
    else if (r < 90) k = 32'd0;
    else k = $urandom;
    p = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
                                      : 5'($urandom_range(0, NPROC - 1));
    return mk(op, k, p);
  endfunction

  // Drive input words; hold data while waiting for ready
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_sem_op(in_ch.data));
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 &&
            $urandom_range(0, 99) >= idle_mix.src_idle) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_words.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Check result words and stall the sink at random
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result %p", out_ch.data));
        end else begin
          exp_w = expected_results.pop_front();
          if (out_ch.data.status !== exp_w.status)
            report($sformatf("status %0d, want %0d", out_ch.data.status, exp_w.status));
          if (out_ch.data.pcb_valid !== exp_w.pcb_valid)
            report($sformatf("pcb_valid %0b, want %0b",
                             out_ch.data.pcb_valid, exp_w.pcb_valid));
          if (out_ch.data.pcb_out !== exp_w.pcb_out)
            report($sformatf("pcb_out %0d, want %0d", out_ch.data.pcb_out, exp_w.pcb_out));
          if (out_ch.data.queue_empty !== exp_w.queue_empty)
            report($sformatf("queue_empty %0b, want %0b",
                             out_ch.data.queue_empty, exp_w.queue_empty));
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= idle_mix.snk_stall);
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    idle_mix = '{0, 0};
    for (int d = 0; d < NPROC; d++) begin
      sem_used[d] = 1'b0;
      pid_blk[d] = 1'b0;
      sem_key[d] = '0; sem_head[d] = '0; sem_tail[d] = '0;
      pid_next[d] = '0; pid_more[d] = 1'b0; pid_sem[d] = '0;
    end
    keys[0] = 32'hFFFF_FFFF;
    keys[1] = 32'd1;
    for (int i = 2; i < 8; i++) keys[i] = $urandom | 32'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: null key, range, blocked, missing, pool full, odd ops
    pending_words.push_back(mk(OP_BUSY, 32'd0, 5'd0));
    pending_words.push_back(mk(OP_INSERT, 32'd0, 5'd1));
    pending_words.push_back(mk(OP_INSERT, 32'hFFFF_FFFF, 5'd31));
    pending_words.push_back(mk(OP_RM_HEAD, 32'hDEAD_BEEF, 5'd0));
    pending_words.push_back(mk(OP_PEEK, 32'd0, 5'd0));
    pending_words.push_back(mk(OP_INSERT, 32'hFFFF_FFFF, 5'd0));
    pending_words.push_back(mk(OP_INSERT, 32'hFFFF_FFFF, 5'd19));
    pending_words.push_back(mk(OP_INSERT, 32'd1, 5'd19));
    pending_words.push_back(mk(OP_PEEK, 32'hFFFF_FFFF, 5'd0));
    pending_words.push_back(mk(OP_BUSY, 32'hFFFF_FFFF, 5'd0));
    pending_words.push_back(mk(OP_RM_PCB, 32'd0, 5'd19));
    pending_words.push_back(mk(OP_RM_PCB, 32'd0, 5'd19));
    pending_words.push_back(mk(OP_RM_PCB, 32'd0, 5'd20));
    pending_words.push_back(mk(OP_RM_HEAD, 32'hFFFF_FFFF, 5'd0));
    pending_words.push_back(mk(3'd5, 32'd5, 5'd1));
    pending_words.push_back(mk(3'd7, 32'hAAAA_5555, 5'd30));
    // Fill the pool with 19 keys, then take the last descriptor
    for (int i = 1; i < 20; i++)
      pending_words.push_back(mk(OP_INSERT, 32'h100 + i, 5'(i)));
    drain();
    pending_words.push_back(mk(OP_INSERT, 32'h5555_AAAA, 5'd0));
    pending_words.push_back(mk(OP_INSERT, 32'h0, 5'd0));
    for (int i = 1; i < 20; i++)
      pending_words.push_back(mk(OP_RM_PCB, 32'd0, 5'(i)));
    drain();

    // Random phases with varied idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_mix = '{0, 0};
        1: idle_mix = '{54, 0};
        2: idle_mix = '{0, 54};
        default: idle_mix = '{23, 23};
      endcase
      for (int i = 0; i < 450; i++) pending_words.push_back(rand_word());
      drain();
    end
    repeat (60) @(posedge clk);

    $display("Ran %0d words through insert, removal, peek and busy queries,",
             words_sent);
    $display("with %0d results checked over four idling mixes.", results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
